// File: design/pcm_gain_ramp_saturate_macros.svh
// ----------------------------------------------------------------------------
// pcm_gain_ramp_saturate_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PCM_GAIN_RAMP_SATURATE_MACROS_SVH
`define PCM_GAIN_RAMP_SATURATE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PGRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgrs assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define PGRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgrs assertion failed");

`endif

// File: design/pgrs_pkg.sv
// ----------------------------------------------------------------------------
// pgrs_pkg
// Widths, constants and types of the PCM gain ramp and saturate block.
// ----------------------------------------------------------------------------
package pgrs_pkg;

  localparam int GAIN_FRAC_BITS = 13;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int POS_W    = 15;

  // weighted gain numerator g0*(n-k) + g1*k, always below 2^31
  localparam int W_W      = GAIN_W + POS_W;
  localparam int PROD_W   = SAMPLE_W + W_W;
  // quotient (|s| * w) / n is below 2^31 since w / n never exceeds a gain
  localparam int Q_W      = W_W;
  localparam int EQP_W    = SAMPLE_W + GAIN_W;
  localparam int EQ_MAG_W = EQP_W + 1 - GAIN_FRAC_BITS;

  localparam logic [GAIN_W:0]   UNITY_GAIN = (GAIN_W + 1)'(1 << GAIN_FRAC_BITS);
  localparam logic [EQP_W:0]    ROUND_HALF = (EQP_W + 1)'(1 << (GAIN_FRAC_BITS - 1));
  localparam logic [EQ_MAG_W-1:0] MAG_MAX_POS = EQ_MAG_W'(32767);
  localparam logic [EQ_MAG_W-1:0] MAG_MAX_NEG = EQ_MAG_W'(32768);
  localparam logic [SAMPLE_W-1:0] SAT_POS    = SAMPLE_W'(16'h7fff);
  localparam logic [SAMPLE_W-1:0] SAT_NEG    = SAMPLE_W'(16'h8000);

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw;
    logic                neg;
    logic                eq;
    logic                unity;
    logic [EQ_MAG_W-1:0] eqmag;
    logic [POS_W-1:0]    n;
  } side_t;

endpackage

// File: design/pcm_gain_ramp_saturate.sv
// ----------------------------------------------------------------------------
// pcm_gain_ramp_saturate
// Applies a fixed or linearly ramped Q3.13 gain to a signed 16-bit sample,
// rounding for a fixed gain, truncating for a ramp, saturating with a flag.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | sample_in, start_gain, end_gain,
//          |                      | sample_position, samples_per_channel
//  output  | out_valid / out_ready| sample_out, clipped
//
//  One item per cycle unless the output stalls. Stages in order: three set-up
//  and multiply stages, the product stage, one stage per quotient bit of the ramp
//  divider (31), and the saturating output register.
//  Reset clears the valid bits only.
//  A stalled output holds every stage, bubbles included, and drops in_ready.
// ----------------------------------------------------------------------------
module pcm_gain_ramp_saturate import pgrs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic        [GAIN_W-1:0]   start_gain,
  input  logic        [GAIN_W-1:0]   end_gain,
  input  logic        [POS_W-1:0]    sample_position,
  input  logic        [POS_W-1:0]    samples_per_channel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       clipped
);

  logic                en;
  logic                empty_ahead;

  // stage 1: set-up
  logic [SAMPLE_W-1:0] raw;
  logic [SAMPLE_W-1:0] amag;
  logic [POS_W-1:0]    n_fix;
  logic [POS_W:0]      pos_inc;
  logic [POS_W-1:0]    k;
  side_t               side_in;

  logic                s1_v;
  logic [SAMPLE_W-1:0] s1_amag;
  logic [GAIN_W-1:0]   s1_g0;
  logic [GAIN_W-1:0]   s1_g1;
  logic [POS_W-1:0]    s1_k;
  logic [POS_W-1:0]    s1_nk;
  side_t               s1_side;

  // stage 2: partial products
  logic                s2_v;
  logic [SAMPLE_W-1:0] s2_amag;
  logic [W_W-1:0]      s2_m0;
  logic [W_W-1:0]      s2_m1;
  logic [EQP_W-1:0]    s2_eqp;
  side_t               s2_side;

  // stage 3: weighted gain, rounded fixed-gain magnitude
  logic [W_W:0]        wsum;
  logic [EQP_W:0]      eqrnd;
  side_t               side3;
  logic                s3_v;
  logic [SAMPLE_W-1:0] s3_amag;
  logic [W_W-1:0]      s3_w;
  side_t               s3_side;

  // divider stages
  logic [PROD_W-1:0]   prod;
  logic                div_v    [0:Q_W];
  logic [POS_W-1:0]    div_rem  [0:Q_W];
  logic [Q_W-1:0]      div_lq   [0:Q_W];
  side_t               div_side [0:Q_W];

  // output
  side_t               fside;
  logic [Q_W-1:0]      quo;
  logic [EQ_MAG_W-1:0] mag;
  logic                over_p;
  logic                over_n;
  logic [SAMPLE_W-1:0] magc;
  logic [SAMPLE_W-1:0] res;

  assign empty_ahead = !out_valid;
  assign en          = empty_ahead || out_ready;
  assign in_ready    = en;

  always_comb begin
    raw     = sample_in;
    amag    = raw[SAMPLE_W-1] ? SAMPLE_W'(~raw + 1'b1) : raw;
    n_fix   = (samples_per_channel == '0) ? POS_W'(1) : samples_per_channel;
    pos_inc = {1'b0, sample_position} + (POS_W + 1)'(1);
    k       = (pos_inc > {1'b0, n_fix}) ? n_fix : pos_inc[POS_W-1:0];
    side_in.raw   = raw;
    side_in.neg   = raw[SAMPLE_W-1];
    side_in.eq    = (start_gain == end_gain);
    side_in.unity = ({1'b0, start_gain} == UNITY_GAIN);
    side_in.eqmag = '0;
    side_in.n     = n_fix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      s1_amag <= amag;
      s1_g0   <= start_gain;
      s1_g1   <= end_gain;
      s1_k    <= k;
      s1_nk   <= n_fix - k;
      s1_side <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_amag <= s1_amag;
      s2_m0   <= W_W'(s1_g0 * s1_nk);
      s2_m1   <= W_W'(s1_g1 * s1_k);
      s2_eqp  <= EQP_W'(s1_amag * s1_g0);
      s2_side <= s1_side;
    end
  end

  always_comb begin
    wsum  = {1'b0, s2_m0} + {1'b0, s2_m1};
    eqrnd = {1'b0, s2_eqp} + ROUND_HALF;
    side3 = s2_side;
    side3.eqmag = EQ_MAG_W'(eqrnd >> GAIN_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
    if (en) begin
      s3_amag <= s2_amag;
      s3_w    <= wsum[W_W-1:0];
      s3_side <= side3;
    end
  end

  assign prod = PROD_W'(s3_amag * s3_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else if (en) begin
      div_v[0] <= s3_v;
    end
    if (en) begin
      div_rem[0]  <= prod[Q_W+POS_W-1:Q_W];
      div_lq[0]   <= prod[Q_W-1:0];
      div_side[0] <= s3_side;
    end
  end

  // restoring division, one quotient bit per stage; quotient bits shift
  // into the low end as dividend bits leave the top
  for (genvar i = 0; i < Q_W; i++) begin : g_div
    logic [POS_W:0] trial;
    logic [POS_W:0] diff;
    logic           ge;

    always_comb begin
      trial = {div_rem[i], div_lq[i][Q_W-1]};
      diff  = trial - {1'b0, div_side[i].n};
      ge    = (trial >= {1'b0, div_side[i].n});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[i+1] <= 1'b0;
      end else if (en) begin
        div_v[i+1] <= div_v[i];
      end
      if (en) begin
        div_rem[i+1]  <= ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
        div_lq[i+1]   <= {div_lq[i][Q_W-2:0], ge};
        div_side[i+1] <= div_side[i];
      end
    end
  end

  always_comb begin
    fside  = div_side[Q_W];
    quo    = div_lq[Q_W];
    mag    = fside.eq ? fside.eqmag : EQ_MAG_W'(quo >> GAIN_FRAC_BITS);
    over_p = !fside.neg && (mag > MAG_MAX_POS);
    over_n = fside.neg && (mag > MAG_MAX_NEG);
    if (over_p) begin
      magc = SAT_POS;
    end else if (over_n) begin
      magc = SAT_NEG;
    end else begin
      magc = mag[SAMPLE_W-1:0];
    end
    res = fside.neg ? SAMPLE_W'(~magc + 1'b1) : magc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_v[Q_W];
    end
    if (en) begin
      if (fside.eq && fside.unity) begin
        sample_out <= fside.raw;
        clipped    <= 1'b0;
      end else begin
        sample_out <= res;
        clipped    <= over_p || over_n;
      end
    end
  end

endmodule

// File: design/pgrs_checker.sv
// ----------------------------------------------------------------------------
// pgrs_checker
// Port-level checks of the PCM gain ramp and saturate block.
// ----------------------------------------------------------------------------
`include "pcm_gain_ramp_saturate_macros.svh"

module pgrs_checker import pgrs_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] sample_out,
  input logic                       clipped
);

  `PGRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({sample_out, clipped}))
  `PGRS_ASSERT_IMP(a_clip_sat, out_valid && clipped, sample_out == SAT_POS || sample_out == SAT_NEG)
  `PGRS_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
  `PGRS_ASSERT_IMP(a_empty_after_reset, $past(rst), !out_valid)

endmodule

bind pcm_gain_ramp_saturate pgrs_checker u_pgrs_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCM gain ramp and saturate block: drives PCM
// items with fixed and ramped gains, predicts each scaled sample and clip flag,
// and checks every result in order under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import pgrs_pkg::*;

  localparam int ITEMS     = 2000;
  localparam int LONG_HOLD = 300;
  localparam int TAIL      = 40;
  localparam int LIMIT     = 400000;
  localparam int SHOW_MAX  = 10;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic        [GAIN_W-1:0]   g0;
    logic        [GAIN_W-1:0]   g1;
    logic        [POS_W-1:0]    pos;
    logic        [POS_W-1:0]    n;
  } gain_item_t;

  typedef struct {
    gain_item_t          item;
    logic [SAMPLE_W-1:0] sample;
    logic                clip;
  } scaled_t;

  class gain_scoreboard;
    scaled_t expected_samples[$];
    int      mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void scaled_sample(gain_item_t it, output logic [SAMPLE_W-1:0] res,
                                output logic clip);
      bit        neg;
      bit [63:0] amag, g0, g1, k, nn, w, mag;
      neg  = it.sample[SAMPLE_W-1];
      amag = neg ? 64'h10000 - {48'h0, it.sample} : {48'h0, it.sample};
      g0   = {48'h0, it.g0};
      g1   = {48'h0, it.g1};
      clip = 1'b0;
      if (it.g0 == it.g1) begin
        if ({1'b0, it.g0} == UNITY_GAIN) begin
          res = it.sample;
          return;
        end
        mag = (amag * g0 + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
      end else begin
        nn = (it.n == '0) ? 64'd1 : {49'h0, it.n};
        k  = {49'h0, it.pos} + 64'd1;
        if (k > nn) k = nn;
        w   = g0 * (nn - k) + g1 * k;
        mag = (amag * w) / (nn << GAIN_FRAC_BITS);
      end
      if (!neg) begin
        if (mag > 64'd32767) begin
          mag  = 64'd32767;
          clip = 1'b1;
        end
        res = mag[SAMPLE_W-1:0];
      end else begin
        if (mag > 64'd32768) begin
          mag  = 64'd32768;
          clip = 1'b1;
        end
        res = SAMPLE_W'(64'd0 - mag);
      end
    endfunction

    function void note_sample(gain_item_t it);
      scaled_t e;
      e.item = it;
      scaled_sample(it, e.sample, e.clip);
      expected_samples = {expected_samples, e};
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] res, logic clip);
      scaled_t e;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected item: sample_out=%0d clipped=%b", $signed(res), clip);
        return;
      end
      e = expected_samples.pop_front();
      if (res !== e.sample || clip !== e.clip) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("mismatch: in=%0d g0=%h g1=%h pos=%0d n=%0d exp %0d/%b got %0d/%b",
                   e.item.sample, e.item.g0, e.item.g1, e.item.pos, e.item.n,
                   $signed(e.sample), e.clip, $signed(res), clip);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic        [GAIN_W-1:0]   start_gain;
  logic        [GAIN_W-1:0]   end_gain;
  logic        [POS_W-1:0]    sample_position;
  logic        [POS_W-1:0]    samples_per_channel;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;

  gain_scoreboard sb;
  int             cycle_count;
  bit             send_burst;

  pcm_gain_ramp_saturate u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .sample_in           (sample_in),
    .start_gain          (start_gain),
    .end_gain            (end_gain),
    .sample_position     (sample_position),
    .samples_per_channel (samples_per_channel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .sample_out          (sample_out),
    .clipped             (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic gain_item_t make_item(int s, int g0, int g1, int pos, int n);
    gain_item_t it;
    it.sample = SAMPLE_W'(s);
    it.g0     = GAIN_W'(g0);
    it.g1     = GAIN_W'(g1);
    it.pos    = POS_W'(pos);
    it.n      = POS_W'(n);
    return it;
  endfunction

  function automatic gain_item_t random_item();
    gain_item_t it;
    int         pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: it.sample = 16'sh8000;
        1: it.sample = 16'sh7fff;
        2: it.sample = '0;
        3: it.sample = -16'sd1;
        default: it.sample = 16'sd1;
      endcase
    end else begin
      it.sample = SAMPLE_W'($urandom);
    end
    if (pick < 10) begin
      it.g0 = UNITY_GAIN[GAIN_W-1:0];
      it.g1 = it.g0;
    end else if (pick < 35) begin
      if ($urandom_range(0, 4) == 0)
        it.g0 = GAIN_W'($urandom_range(8180, 8204));
      else
        it.g0 = GAIN_W'($urandom);
      it.g1 = it.g0;
    end else begin
      it.g0 = GAIN_W'($urandom);
      if ($urandom_range(0, 5) == 0 && it.g0 != '1)
        it.g1 = it.g0 + 1'b1;
      else
        it.g1 = GAIN_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 5)
      it.n = '0;
    else if (pick < 15)
      it.n = POS_W'($urandom_range(1, 8));
    else if (pick < 20)
      it.n = '1;
    else
      it.n = POS_W'($urandom_range(1, 32767));
    if (it.n == '0 || $urandom_range(0, 9) == 0)
      it.pos = POS_W'($urandom);
    else
      it.pos = POS_W'($urandom_range(0, int'(it.n) - 1));
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(gain_item_t it);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_in           <= it.sample;
    start_gain          <= it.g0;
    end_gain            <= it.g1;
    sample_position     <= it.pos;
    samples_per_channel <= it.n;
    in_valid            <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(it);
    @(negedge clk);
  endtask

  // receiving side: random stalls, two long hold-offs to back the pipeline up
  initial begin
    int results;
    int gap;
    results   = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results == 300 || results == 1200) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = ((results / 200) % 4 == 2) ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_sample(sample_out, clipped);
      results++;
      @(negedge clk);
    end
  end

  initial begin
    gain_item_t directed[$];
    bit         failed;
    sb                  = new();
    send_burst          = 1'b0;
    rst                 = 1'b1;
    in_valid            = 1'b0;
    sample_in           = '0;
    start_gain          = '0;
    end_gain            = '0;
    sample_position     = '0;
    samples_per_channel = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unity gain passes the sample untouched
    directed = {directed, make_item(-32768, 'h2000, 'h2000, 0, 1)};
    directed = {directed, make_item(32767, 'h2000, 'h2000, 32767, 0)};
    // fixed gain: zero, maximum with clipping both ways, rounding half away from zero
    directed = {directed, make_item(-32768, 0, 0, 0, 1)};
    directed = {directed, make_item(32767, 'hffff, 'hffff, 0, 1)};
    directed = {directed, make_item(-32768, 'hffff, 'hffff, 0, 1)};
    directed = {directed, make_item(1, 'h1000, 'h1000, 0, 1)};
    directed = {directed, make_item(-1, 'h1000, 'h1000, 0, 1)};
    directed = {directed, make_item(3, 'h1000, 'h1000, 0, 1)};
    directed = {directed, make_item(-32767, 'h2001, 'h2001, 0, 1)};
    // ramp lands exactly on -32768, no clip
    directed = {directed, make_item(-32768, 'h2000, 'h2001, 0, 32767)};
    // tiny ramp step
    directed = {directed, make_item(32767, 'h2000, 'h2001, 0, 32767)};
    directed = {directed, make_item(32767, 'h2001, 'h2000, 16383, 32767)};
    // full-range ramp, over one sample and over a long frame
    directed = {directed, make_item(32767, 0, 'hffff, 0, 1)};
    directed = {directed, make_item(-32768, 'hffff, 0, 0, 32767)};
    // zero length frame
    directed = {directed, make_item(12345, 'h0800, 'h6000, 0, 0)};
    directed = {directed, make_item(-12345, 'h6000, 'h0800, 32767, 0)};
    // position past the end holds at end gain
    directed = {directed, make_item(20000, 'h2000, 'h4000, 32767, 5)};
    directed = {directed, make_item(-20000, 'h4000, 'h2000, 32766, 32767)};
    directed = {directed, make_item(0, 0, 1, 0, 1)};
    directed = {directed, make_item(-1, 'hffff, 'hfffe, 100, 200)};
    foreach (directed[i]) send_item(directed[i]);

    for (int i = 0; i < ITEMS; i++) begin
      send_burst = ((i / 150) % 4 == 3);
      send_item(random_item());
    end
    in_valid <= 1'b0;

    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    failed = (sb.mismatches != 0) || (sb.expected_samples.size() != 0);
    if (sb.expected_samples.size() != 0)
      $display("%0d expected items never arrived", sb.expected_samples.size());
    if (!failed)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
